>>> rtl/core/qlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types and constants of the Q-learning table engine.
// ----------------------------------------------------------------------------
package qlt_pkg;

    localparam int NUM_STATES  = 256;
    localparam int MAX_ACTIONS = 8;

    localparam int ROW_W    = $clog2(NUM_STATES);
    localparam int ACT_W    = $clog2(MAX_ACTIONS);
    localparam int Q_DEPTH  = NUM_STATES * MAX_ACTIONS;
    localparam int Q_ADDR_W = $clog2(Q_DEPTH);
    localparam int CNT_W    = $clog2(MAX_ACTIONS + 1);

    localparam int OP_W     = 2;
    localparam int STATE_W  = 8;
    localparam int Q_W      = 32;
    localparam int PROB_W   = 17;
    localparam int NACT_W   = 4;
    localparam int MASK_W   = 8;
    localparam int RAND_W   = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_SELECT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_GREEDY   = 2'd0,
        REG_LRATE    = 2'd1,
        REG_DISCOUNT = 2'd2,
        REG_NUM_ACT  = 2'd3
    } t_reg;

    // Source of a RAM read, carried along with the read to steer the data.
    typedef enum logic [1:0] {
        RD_ROW    = 2'd0,
        RD_NEXT   = 2'd1,
        RD_ENTRY  = 2'd2,
        RD_CHOSEN = 2'd3
    } t_rd_src;

    // Effective config; lrate, discount and num_act clamped to legal ranges.
    typedef struct packed {
        logic [PROB_W-1:0] greedy_prob;
        logic [PROB_W-1:0] lrate;
        logic [PROB_W-1:0] discount;
        logic [NACT_W-1:0] num_act;
    } t_cfg;

    typedef struct packed {
        logic                load;
        logic                rd_en;
        t_rd_src             rd_src;
        logic [ACT_W-1:0]    idx;
        logic                clr_en;
        logic [Q_ADDR_W-1:0] clr_addr;
        logic                pick;
        logic                choose;
        logic                mul1;
        logic                diff;
        logic                mul2;
        logic                upd_wr;
        logic                wval_wr;
        logic                res_load;
        t_op                 res_op;
    } t_cmd;

endpackage

>>> rtl/core/qlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/qlt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_cfg
// Configuration registers on the APB port, with range clamping.
// ----------------------------------------------------------------------------
module qlt_cfg import qlt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [PROB_W-1:0] r_greedy;
    logic [PROB_W-1:0] r_lrate;
    logic [PROB_W-1:0] r_discount;
    logic [NACT_W-1:0] r_num_act;
    logic              wr_en;
    t_reg              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_greedy   <= '0;
            r_lrate    <= PROB_W'(6554);
            r_discount <= PROB_W'(58982);
            r_num_act  <= NACT_W'(MAX_ACTIONS);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_GREEDY:   r_greedy   <= pwdata[PROB_W-1:0];
                REG_LRATE:    r_lrate    <= pwdata[PROB_W-1:0];
                REG_DISCOUNT: r_discount <= pwdata[PROB_W-1:0];
                REG_NUM_ACT:  r_num_act  <= pwdata[NACT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_GREEDY:   prdata = PDATA_W'(r_greedy);
            REG_LRATE:    prdata = PDATA_W'(r_lrate);
            REG_DISCOUNT: prdata = PDATA_W'(r_discount);
            REG_NUM_ACT:  prdata = PDATA_W'(r_num_act);
            default:      prdata = '0;
        endcase
    end

    // Rates above one act as one; an action count of zero acts as one.
    always_comb begin
        o_cfg.greedy_prob = r_greedy;
        o_cfg.lrate       = (r_lrate > ONE_Q16) ? ONE_Q16 : r_lrate;
        o_cfg.discount    = (r_discount > ONE_Q16) ? ONE_Q16 : r_discount;
        if (r_num_act == '0) begin
            o_cfg.num_act = NACT_W'(1);
        end else if (r_num_act > NACT_W'(MAX_ACTIONS)) begin
            o_cfg.num_act = NACT_W'(MAX_ACTIONS);
        end else begin
            o_cfg.num_act = r_num_act;
        end
    end

endmodule

>>> rtl/core/qlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_ctrl
// Sequencer: clears the table after reset, then steps each request
// through its reads, pick, update arithmetic or write, and result.
// ----------------------------------------------------------------------------
module qlt_ctrl import qlt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [OP_W-1:0]   i_op,
    input  logic              i_end_of_episode,
    input  logic [NACT_W-1:0] i_num_act,
    output logic              o_busy,
    output logic              o_done,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RDQ,
        S_SCAN_N,
        S_SCAN_END,
        S_PICK,
        S_CHOOSE,
        S_RDC,
        S_MUL1,
        S_DIFF,
        S_MUL2,
        S_FINAL,
        S_WRITE,
        S_RESULT
    } t_state;

    t_state              r_state, n_state;
    logic [ACT_W-1:0]    r_idx, n_idx;
    logic [Q_ADDR_W-1:0] r_clr, n_clr;
    t_op                 r_op, n_op;
    logic                r_eoe, n_eoe;
    logic                r_done, n_done;
    logic                last_next;

    assign last_next = ({1'b0, r_idx} == (i_num_act - NACT_W'(1)));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_clr   = r_clr;
        n_op    = r_op;
        n_eoe   = r_eoe;
        n_done  = 1'b0;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_cmd.clr_addr = r_clr;
        o_cmd.res_op   = r_op;
        o_cmd.rd_src   = RD_ROW;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                n_clr = r_clr + Q_ADDR_W'(1);
                if (r_clr == Q_ADDR_W'(Q_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op  = t_op'(i_op);
                    n_eoe = i_end_of_episode;
                    n_idx = '0;
                    unique case (t_op'(i_op))
                        OP_SELECT: n_state = S_SCAN;
                        OP_UPDATE: n_state = S_RDQ;
                        OP_READ:   n_state = S_RDQ;
                        OP_WRITE:  n_state = S_WRITE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_ROW;
                n_idx = r_idx + ACT_W'(1);
                if (r_idx == ACT_W'(MAX_ACTIONS - 1)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_RDQ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_ENTRY;
                if (r_op == OP_READ) begin
                    n_state = S_RESULT;
                end else if (r_eoe) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_state = S_SCAN_N;
                end
            end
            S_SCAN_N: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_NEXT;
                n_idx = r_idx + ACT_W'(1);
                if (last_next) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // The last read of the scan lands in this cycle.
                n_state = (r_op == OP_SELECT) ? S_PICK : S_MUL1;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_CHOOSE;
            end
            S_CHOOSE: begin
                o_cmd.choose = 1'b1;
                n_state = S_RDC;
            end
            S_RDC: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = RD_CHOSEN;
                n_state = S_RESULT;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.upd_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_WRITE: begin
                o_cmd.wval_wr  = 1'b1;
                o_cmd.res_load = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_RESULT: begin
                o_cmd.res_load = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_clr   <= '0;
            r_op    <= OP_SELECT;
            r_eoe   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_clr   <= n_clr;
            r_op    <= n_op;
            r_eoe   <= n_eoe;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

>>> rtl/core/qlt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_dpath
// Datapath: Q table RAM, request registers, row max tracking, candidate
// pick, fixed-point update arithmetic and result registers.
// ----------------------------------------------------------------------------
module qlt_dpath import qlt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    input  logic [STATE_W-1:0] i_state,
    input  logic [ACT_W-1:0]   i_action,
    input  logic signed [Q_W-1:0] i_reward,
    input  logic [STATE_W-1:0] i_succ_state,
    input  logic               i_end_of_episode,
    input  logic [MASK_W-1:0]  i_allowed_mask,
    input  logic [RAND_W-1:0]  i_rand_unit,
    input  logic [RAND_W-1:0]  i_rand_pick,
    input  logic signed [Q_W-1:0] i_entry_value,
    output logic [ACT_W-1:0]   o_chosen_action,
    output logic signed [Q_W-1:0] o_q_value,
    output logic               o_status
);

    localparam int P1_W   = PROB_W + 1 + Q_W;
    localparam int DIFF_W = Q_W + 4;
    localparam int P2_W   = PROB_W + 1 + DIFF_W;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Request registers
    logic [ROW_W-1:0]       r_row;
    logic [ACT_W-1:0]       r_act;
    logic signed [Q_W-1:0]  r_reward;
    logic [ROW_W-1:0]       r_next_row;
    logic                   r_eoe;
    logic [MAX_ACTIONS-1:0] r_cand;
    logic                   r_greedy;
    logic [RAND_W-1:0]      r_rand_pick;
    logic signed [Q_W-1:0]  r_wval;

    // Scan and arithmetic registers
    logic                   r_rd_vld;
    t_rd_src                r_rd_src;
    logic [ACT_W-1:0]       r_rd_idx;
    logic signed [Q_W-1:0]  r_best;
    logic [MAX_ACTIONS-1:0] r_maxset;
    logic signed [Q_W-1:0]  r_q;
    logic [CNT_W-1:0]       r_pick_n;
    logic [ACT_W-1:0]       r_chosen;
    logic signed [P1_W-1:0] r_prod1;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [P2_W-1:0] r_prod2;

    // Result registers
    logic [ACT_W-1:0]       r_res_act;
    logic signed [Q_W-1:0]  r_res_q;
    logic                   r_res_status;

    // RAM signals
    logic                   ram_we;
    logic [Q_ADDR_W-1:0]    ram_waddr;
    logic [Q_W-1:0]         ram_wdata;
    logic [Q_ADDR_W-1:0]    ram_raddr;
    logic [Q_W-1:0]         ram_rdata;
    logic signed [Q_W-1:0]  rdata;

    logic [MAX_ACTIONS-1:0] act_mask;
    logic [MAX_ACTIONS-1:0] fcand;
    logic [CNT_W-1:0]       cand_cnt;
    logic [RAND_W+CNT_W-1:0] pick_prod;
    logic [ACT_W-1:0]       chosen;
    logic [CNT_W-1:0]       seen;
    logic                   found;
    logic signed [P1_W-1:0] rnd1;
    logic signed [DIFF_W-1:0] target;
    logic signed [P2_W-1:0] rnd2;
    logic signed [P2_W-1:0] nv_full;
    logic signed [Q_W-1:0]  nv;
    logic                   sel_none;

    assign rdata = ram_rdata;

    qlt_ram #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_qtab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            act_mask[a] = (NACT_W'(a) < i_cfg.num_act);
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            RD_ROW:    ram_raddr = {r_row, i_cmd.idx};
            RD_NEXT:   ram_raddr = {r_next_row, i_cmd.idx};
            RD_ENTRY:  ram_raddr = {r_row, r_act};
            RD_CHOSEN: ram_raddr = {r_row, r_chosen};
            default:   ram_raddr = {r_row, r_act};
        endcase
    end

    always_comb begin
        ram_we    = i_cmd.clr_en || i_cmd.upd_wr || i_cmd.wval_wr;
        ram_waddr = {r_row, r_act};
        ram_wdata = r_wval;
        if (i_cmd.clr_en) begin
            ram_waddr = i_cmd.clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.upd_wr) begin
            ram_wdata = nv;
        end
    end

    // Candidate set, count and the pick-th member in ascending order.
    always_comb begin
        fcand    = r_greedy ? r_maxset : r_cand;
        cand_cnt = '0;
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            cand_cnt = cand_cnt + CNT_W'(fcand[a]);
        end
        pick_prod = r_rand_pick * cand_cnt;
    end

    always_comb begin
        chosen = '0;
        seen   = '0;
        found  = 1'b0;
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            if (fcand[a]) begin
                if (!found && seen == r_pick_n) begin
                    chosen = ACT_W'(a);
                    found  = 1'b1;
                end
                seen = seen + CNT_W'(1);
            end
        end
    end

    // Products are rounded to nearest with ties toward +infinity.
    always_comb begin
        rnd1   = (r_prod1 + P1_W'(32768)) >>> 16;
        target = DIFF_W'(r_reward) - DIFF_W'(r_q);
        if (!r_eoe) begin
            target = target + DIFF_W'(rnd1);
        end
        rnd2    = (r_prod2 + P2_W'(32768)) >>> 16;
        nv_full = rnd2 + P2_W'(r_q);
        if (nv_full > P2_W'(Q_MAX)) begin
            nv = Q_MAX;
        end else if (nv_full < P2_W'(Q_MIN)) begin
            nv = Q_MIN;
        end else begin
            nv = nv_full[Q_W-1:0];
        end
    end

    assign sel_none = (r_cand == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_src <= i_cmd.rd_src;
            r_rd_idx <= i_cmd.idx;
        end

        if (i_cmd.load) begin
            r_row       <= i_state[ROW_W-1:0];
            r_act       <= i_action;
            r_reward    <= i_reward;
            r_next_row  <= i_succ_state[ROW_W-1:0];
            r_eoe       <= i_end_of_episode;
            r_cand      <= i_allowed_mask[MAX_ACTIONS-1:0] & act_mask;
            r_greedy    <= ({1'b0, i_rand_unit} < i_cfg.greedy_prob);
            r_rand_pick <= i_rand_pick;
            r_wval      <= i_entry_value;
            r_best      <= Q_MIN;
            r_maxset    <= '0;
        end else if (r_rd_vld) begin
            case (r_rd_src)
                RD_ROW: begin
                    if (r_cand[r_rd_idx]) begin
                        if (rdata > r_best) begin
                            r_best   <= rdata;
                            r_maxset <= MAX_ACTIONS'(1) << r_rd_idx;
                        end else if (rdata == r_best) begin
                            r_maxset[r_rd_idx] <= 1'b1;
                        end
                    end
                end
                RD_NEXT: begin
                    if (r_rd_idx == '0 || rdata > r_best) begin
                        r_best <= rdata;
                    end
                end
                RD_ENTRY: r_q <= rdata;
                default:  ;
            endcase
        end

        if (i_cmd.pick) begin
            r_pick_n <= pick_prod[RAND_W+CNT_W-1:RAND_W];
        end
        if (i_cmd.choose) begin
            r_chosen <= chosen;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= $signed({1'b0, i_cfg.discount}) * r_best;
        end
        if (i_cmd.diff) begin
            r_diff <= target;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= $signed({1'b0, i_cfg.lrate}) * r_diff;
        end

        if (i_cmd.res_load) begin
            case (i_cmd.res_op)
                OP_SELECT: begin
                    r_res_act    <= sel_none ? '0 : r_chosen;
                    r_res_q      <= sel_none ? '0 : rdata;
                    r_res_status <= sel_none;
                end
                OP_UPDATE: begin
                    r_res_act    <= r_act;
                    r_res_q      <= nv;
                    r_res_status <= 1'b0;
                end
                OP_READ: begin
                    r_res_act    <= r_act;
                    r_res_q      <= rdata;
                    r_res_status <= 1'b0;
                end
                default: begin
                    r_res_act    <= r_act;
                    r_res_q      <= r_wval;
                    r_res_status <= 1'b0;
                end
            endcase
        end
    end

    assign o_chosen_action = r_res_act;
    assign o_q_value       = r_res_q;
    assign o_status        = r_res_status;

endmodule

>>> rtl/core/q_learning_table_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_learning_table_engine_unit
// Tabular Q-learning engine: epsilon-greedy action select, Q update, and
// entry read and write over a 256 x 8 table of signed Q16.16 values.
// ----------------------------------------------------------------------------
// After reset the block clears all 2048 table entries with busy high;
// configuration writes are taken during that time. A request is taken when
// start is high and busy is low, and its result appears on o_done for one
// cycle, which the receiver must take as it comes. Requests are processed
// one at a time, and the table RAM, read one entry per cycle, sets the
// length: a select holds busy through an eight-entry row scan, the pick and
// a read of the chosen entry; an update through the entry read, a next-row
// scan unless at episode end, and two multiplies; a read through one entry
// read; a write through one write. The result strobe is high in the first
// cycle with busy low, and a new request may be given in that cycle.
// ----------------------------------------------------------------------------
module q_learning_table_engine_unit import qlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [STATE_W-1:0]    i_state,
    input  logic [ACT_W-1:0]      i_action,
    input  logic signed [Q_W-1:0] i_reward,
    input  logic [STATE_W-1:0]    i_succ_state,
    input  logic                  i_end_of_episode,
    input  logic [MASK_W-1:0]     i_allowed_mask,
    input  logic [RAND_W-1:0]     i_rand_unit,
    input  logic [RAND_W-1:0]     i_rand_pick,
    input  logic signed [Q_W-1:0] i_entry_value,
    output logic                  o_done,
    output logic [ACT_W-1:0]      o_chosen_action,
    output logic signed [Q_W-1:0] o_q_value,
    output logic                  o_status
);

    t_cfg cfg;
    t_cmd cmd;

    qlt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qlt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_op             (i_op),
        .i_end_of_episode (i_end_of_episode),
        .i_num_act        (cfg.num_act),
        .o_busy           (busy),
        .o_done           (o_done),
        .o_cmd            (cmd)
    );

    qlt_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_state          (i_state),
        .i_action         (i_action),
        .i_reward         (i_reward),
        .i_succ_state     (i_succ_state),
        .i_end_of_episode (i_end_of_episode),
        .i_allowed_mask   (i_allowed_mask),
        .i_rand_unit      (i_rand_unit),
        .i_rand_pick      (i_rand_pick),
        .i_entry_value    (i_entry_value),
        .o_chosen_action  (o_chosen_action),
        .o_q_value        (o_q_value),
        .o_status         (o_status)
    );

endmodule
